/* sv/qtr_pkg.sv */
// Package for the quaternion to rotation matrix block.
// Holds the widths, the payload structs of both channels and the 3x3 entry layout.
// No dependencies.
package qtr_pkg;

	// Input component width and output fraction bits.
	localparam int IN_W   = 16;
	localparam int FRAC   = 14;
	localparam int OUT_W  = FRAC + 2;
	// Square, cross product, norm and remainder widths.
	localparam int SQ_W   = 2 * IN_W - 1;
	localparam int PR_W   = 2 * IN_W;
	localparam int S_W    = 2 * IN_W + 1;
	localparam int REM_W  = S_W + 1;
	// Quotient bits: one integer bit, FRAC bits and one rounding bit.
	localparam int QB     = FRAC + 2;
	localparam int NSTEP  = QB;
	localparam int NENT   = 9;

	typedef struct packed {
		logic signed [IN_W-1:0] q_real;
		logic signed [IN_W-1:0] q_i;
		logic signed [IN_W-1:0] q_j;
		logic signed [IN_W-1:0] q_k;
	} quat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] m00;
		logic signed [OUT_W-1:0] m01;
		logic signed [OUT_W-1:0] m02;
		logic signed [OUT_W-1:0] m10;
		logic signed [OUT_W-1:0] m11;
		logic signed [OUT_W-1:0] m12;
		logic signed [OUT_W-1:0] m20;
		logic signed [OUT_W-1:0] m21;
		logic signed [OUT_W-1:0] m22;
		logic                    zero_error;
	} mat_t;

endpackage

/* sv/qtr_if.sv */
// Valid/ready channel interfaces for quaternion requests and matrix results.
// Depends on qtr_pkg for the payload types.
interface qtr_quat_if;
	logic          valid;
	logic          ready;
	qtr_pkg::quat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qtr_mat_if;
	logic         valid;
	logic         ready;
	qtr_pkg::mat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/quaternion_to_rotation_matrix.sv */
// Top level of the quaternion to rotation matrix block.
// Depends on qtr_pkg and the channel interfaces in qtr_if.
//
// Usage:
//   quat carries one quaternion (q_real, q_i, q_j, q_k) per request, at any
//   common scale. mat carries the nine entries m00..m22 in Q1.14, rounded to
//   nearest with ties away from zero and clamped to +/-1.0, plus zero_error,
//   which is set for an all-zero quaternion whose matrix is the identity.
//   Normalization divides each entry by a^2+b^2+c^2+d^2 exactly.
//   From acceptance to the result on mat there is one stage of
//   multipliers, one of sums and magnitudes, 16 restoring division steps
//   (one quotient bit per stage, nine dividers in parallel) and one rounding
//   and output stage. Throughput is one request per cycle while the receiver
//   does not stall; the division chain length sets the latency.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and quat.ready drops, so nothing is lost or repeated.
module quaternion_to_rotation_matrix (
	input  logic        clk,
	input  logic        arst_n,
	qtr_quat_if.sink    quat,
	qtr_mat_if.source   mat
);

	localparam int IW = qtr_pkg::IN_W;
	localparam int SW = qtr_pkg::SQ_W;
	localparam int PW = qtr_pkg::PR_W;
	localparam int NW = qtr_pkg::S_W;
	localparam int RW = qtr_pkg::REM_W;
	localparam int QW = qtr_pkg::QB;
	localparam int NS = qtr_pkg::NSTEP;
	localparam int NE = qtr_pkg::NENT;
	localparam int FR = qtr_pkg::FRAC;
	localparam int OW = qtr_pkg::OUT_W;

	logic adv;
	logic out_valid_q;
	qtr_pkg::mat_t out_q;

	// The pipeline moves as a whole when the output register can take data.
	assign adv = !out_valid_q || mat.ready;
	assign quat.ready = adv;

	// Stage 1: squares and cross products.
	logic                 v_s1;
	logic [SW-1:0]        a2_s1, b2_s1, c2_s1, d2_s1;
	logic signed [PW-1:0] ba_s1, ca_s1, da_s1, bc_s1, bd_s1, cd_s1;
	logic signed [IW-1:0] qa, qb, qc, qd;

	assign qa = quat.data.q_real;
	assign qb = quat.data.q_i;
	assign qc = quat.data.q_j;
	assign qd = quat.data.q_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= quat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a2_s1 <= SW'(PW'(qa * qa));
			b2_s1 <= SW'(PW'(qb * qb));
			c2_s1 <= SW'(PW'(qc * qc));
			d2_s1 <= SW'(PW'(qd * qd));
			ba_s1 <= PW'(qb * qa);
			ca_s1 <= PW'(qc * qa);
			da_s1 <= PW'(qd * qa);
			bc_s1 <= PW'(qb * qc);
			bd_s1 <= PW'(qb * qd);
			cd_s1 <= PW'(qc * qd);
		end
	end

	// Magnitude and sign of a signed difference of diagonal sums.
	function automatic logic [NW:0] diag_mag(input logic [NW-2:0] x, input logic [NW-2:0] y);
		logic neg;
		logic [NW-2:0] m;
		neg = x < y;
		m = neg ? (y - x) : (x - y);
		return {neg, 1'b0, m};
	endfunction

	// Magnitude and sign of twice a signed off-diagonal difference.
	function automatic logic [NW:0] off_mag(input logic signed [PW:0] diff);
		logic neg;
		logic [PW:0] m;
		neg = diff[PW];
		m = neg ? (-diff) : diff;
		return {neg, m[PW-1:0], 1'b0};
	endfunction

	// Stage 2: norm, numerator magnitudes and signs.
	logic          v_s2, zero_s2;
	logic [NW-1:0] s_s2;
	logic [NW-1:0] mag_s2 [NE];
	logic [NE-1:0] neg_s2;
	logic [NW-2:0] sab, scd, sac, sbd, sad, sbc;
	logic [NW:0]   ent [NE];
	logic signed [PW:0] ba_x, ca_x, da_x, bc_x, bd_x, cd_x;

	always_comb begin
		sab = (NW-1)'(a2_s1) + (NW-1)'(b2_s1);
		scd = (NW-1)'(c2_s1) + (NW-1)'(d2_s1);
		sac = (NW-1)'(a2_s1) + (NW-1)'(c2_s1);
		sbd = (NW-1)'(b2_s1) + (NW-1)'(d2_s1);
		sad = (NW-1)'(a2_s1) + (NW-1)'(d2_s1);
		sbc = (NW-1)'(b2_s1) + (NW-1)'(c2_s1);
		ba_x = (PW+1)'(ba_s1);
		ca_x = (PW+1)'(ca_s1);
		da_x = (PW+1)'(da_s1);
		bc_x = (PW+1)'(bc_s1);
		bd_x = (PW+1)'(bd_s1);
		cd_x = (PW+1)'(cd_s1);
		ent[0] = diag_mag(sab, scd);
		ent[1] = off_mag(bc_x - da_x);
		ent[2] = off_mag(bd_x + ca_x);
		ent[3] = off_mag(bc_x + da_x);
		ent[4] = diag_mag(sac, sbd);
		ent[5] = off_mag(cd_x - ba_x);
		ent[6] = off_mag(bd_x - ca_x);
		ent[7] = off_mag(cd_x + ba_x);
		ent[8] = diag_mag(sad, sbc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2    <= NW'(sab) + NW'(scd);
			zero_s2 <= (sab == '0) && (scd == '0);
			for (int e = 0; e < NE; e++) begin
				neg_s2[e] <= ent[e][NW];
				mag_s2[e] <= ent[e][NW-1:0];
			end
		end
	end

	// Division stages: one restoring step per stage, nine dividers side by side.
	logic          dv_v    [NS];
	logic          dv_zero [NS];
	logic [NW-1:0] dv_s    [NS];
	logic [NE-1:0] dv_neg  [NS];
	logic [RW-1:0] dv_rem  [NS][NE];
	logic [QW-1:0] dv_quo  [NS][NE];

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [RW-1:0] rin  [NE];
		logic [QW-1:0] qin  [NE];
		logic [NW-1:0] sin;
		logic [RW-1:0] rnx  [NE];
		logic [QW-1:0] qnx  [NE];

		// Shift the partial remainder in and try one subtraction.
		always_comb begin
			sin = (k == 0) ? s_s2 : dv_s[(k == 0) ? 0 : k-1];
			for (int e = 0; e < NE; e++) begin
				if (k == 0) begin
					rin[e] = RW'(mag_s2[e]);
					qin[e] = '0;
				end else begin
					rin[e] = {dv_rem[(k == 0) ? 0 : k-1][e][RW-2:0], 1'b0};
					qin[e] = {dv_quo[(k == 0) ? 0 : k-1][e][QW-2:0], 1'b0};
				end
				if (rin[e] >= RW'(sin)) begin
					rnx[e] = rin[e] - RW'(sin);
					qnx[e] = qin[e] | QW'(1);
				end else begin
					rnx[e] = rin[e];
					qnx[e] = qin[e];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k] <= 1'b0;
			end else if (adv) begin
				dv_v[k] <= (k == 0) ? v_s2 : dv_v[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k]    <= sin;
				dv_zero[k] <= (k == 0) ? zero_s2 : dv_zero[(k == 0) ? 0 : k-1];
				dv_neg[k]  <= (k == 0) ? neg_s2 : dv_neg[(k == 0) ? 0 : k-1];
				for (int e = 0; e < NE; e++) begin
					dv_rem[k][e] <= rnx[e];
					dv_quo[k][e] <= qnx[e];
				end
			end
		end
	end

	// Final stage: round, clamp, apply sign, substitute identity for zero input.
	logic signed [OW-1:0] res [NE];
	logic [QW:0]          rnd [NE];

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			rnd[e] = ((QW+1)'(dv_quo[NS-1][e]) + (QW+1)'(1)) >> 1;
			if (rnd[e] > (QW+1)'(1 << FR)) begin
				rnd[e] = (QW+1)'(1 << FR);
			end
			if (dv_zero[NS-1]) begin
				res[e] = (e == 0 || e == 4 || e == 8) ? OW'(1 << FR) : '0;
			end else if (dv_neg[NS-1][e]) begin
				res[e] = -OW'(rnd[e]);
			end else begin
				res[e] = OW'(rnd[e]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_v[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.m00        <= res[0];
			out_q.m01        <= res[1];
			out_q.m02        <= res[2];
			out_q.m10        <= res[3];
			out_q.m11        <= res[4];
			out_q.m12        <= res[5];
			out_q.m20        <= res[6];
			out_q.m21        <= res[7];
			out_q.m22        <= res[8];
			out_q.zero_error <= dv_zero[NS-1];
		end
	end

	assign mat.valid = out_valid_q;
	assign mat.data  = out_q;

endmodule

/* test/tb.sv */
// Self-checking testbench for quaternion_to_rotation_matrix.
// Depends on qtr_pkg, the channel interfaces in qtr_if and the block itself.
// A built-in predictor computes the exactly normalized matrix for every quaternion request.
module tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;

	qtr_quat_if quat ();
	qtr_mat_if mat ();

	quaternion_to_rotation_matrix dut (
		.clk(clk),
		.arst_n(arst_n),
		.quat(quat),
		.mat(mat)
	);

	// Expected matrices, oldest first.
	qtr_pkg::mat_t expected_mats[$];
	int mismatches;
	int matrices_seen;
	int requests_sent;
	int zero_requests;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Rounded, saturated Q1.FRAC value of sign*mag/s by long division.
	function automatic logic signed [qtr_pkg::OUT_W-1:0] ratio_to_q(bit neg,
			logic [79:0] mag, logic [79:0] s);
		logic [79:0] rem;
		logic [31:0] quo;
		rem = mag;
		quo = 0;
		if (rem >= s) begin
			rem = rem - s;
			quo = 1;
		end
		for (int i = 0; i < qtr_pkg::FRAC + 1; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= s) begin
				rem = rem - s;
				quo = quo | 1;
			end
		end
		quo = (quo + 1) >> 1;
		if (quo > (32'd1 << qtr_pkg::FRAC))
			quo = 32'd1 << qtr_pkg::FRAC;
		return neg ? qtr_pkg::OUT_W'(-quo) : qtr_pkg::OUT_W'(quo);
	endfunction

	// Entry for (x - y)/s, with x and y signed and already scaled.
	function automatic logic signed [qtr_pkg::OUT_W-1:0] entry_of(longint x, longint y,
			logic [79:0] s);
		bit neg;
		logic [79:0] mag;
		neg = x < y;
		mag = neg ? 80'(y - x) : 80'(x - y);
		return ratio_to_q(neg, mag, s);
	endfunction

	function automatic qtr_pkg::mat_t rotation_of(qtr_pkg::quat_t q);
		qtr_pkg::mat_t m;
		longint a, b, c, d, a2, b2, c2, d2;
		logic [79:0] s;
		a = q.q_real;
		b = q.q_i;
		c = q.q_j;
		d = q.q_k;
		a2 = a * a;
		b2 = b * b;
		c2 = c * c;
		d2 = d * d;
		s = 80'(a2) + 80'(b2) + 80'(c2) + 80'(d2);
		m = '0;
		if (s == 0) begin
			m.m00 = qtr_pkg::OUT_W'(1 << qtr_pkg::FRAC);
			m.m11 = qtr_pkg::OUT_W'(1 << qtr_pkg::FRAC);
			m.m22 = qtr_pkg::OUT_W'(1 << qtr_pkg::FRAC);
			m.zero_error = 1'b1;
			return m;
		end
		m.m00 = entry_of(a2 + b2, c2 + d2, s);
		m.m01 = entry_of(2 * b * c, 2 * d * a, s);
		m.m02 = entry_of(2 * b * d, -2 * c * a, s);
		m.m10 = entry_of(2 * b * c, -2 * d * a, s);
		m.m11 = entry_of(a2 + c2, b2 + d2, s);
		m.m12 = entry_of(2 * c * d, 2 * b * a, s);
		m.m20 = entry_of(2 * b * d, 2 * c * a, s);
		m.m21 = entry_of(2 * c * d, -2 * b * a, s);
		m.m22 = entry_of(a2 + d2, b2 + c2, s);
		return m;
	endfunction

	// Send one quaternion request, idling beforehand at the current rate.
	// Valid stays high after the request so the next one can follow at once.
	task automatic send_quat(qtr_pkg::quat_t q);
		while ($urandom_range(99) < idle_pct) begin
			quat.valid <= 1'b0;
			@(posedge clk);
		end
		quat.valid <= 1'b1;
		quat.data <= q;
		@(posedge clk);
		while (!quat.ready)
			@(posedge clk);
		expected_mats.push_back(rotation_of(q));
		requests_sent++;
		if (q == '0)
			zero_requests++;
	endtask

	function automatic qtr_pkg::quat_t make_quat(int a, int b, int c, int d);
		qtr_pkg::quat_t q;
		q.q_real = qtr_pkg::IN_W'(a);
		q.q_i = qtr_pkg::IN_W'(b);
		q.q_j = qtr_pkg::IN_W'(c);
		q.q_k = qtr_pkg::IN_W'(d);
		return q;
	endfunction

	// Raw random bits, random bits scaled down by a shift, small components of -1 to 2, or q_j and q_k shifted down.
	function automatic qtr_pkg::quat_t random_quat();
		int sh;
		qtr_pkg::quat_t q;
		q = qtr_pkg::quat_t'({$urandom, $urandom});
		case ($urandom_range(3))
			0: return q;
			1: begin
				sh = $urandom_range(15);
				q.q_real = q.q_real >>> sh;
				q.q_i = q.q_i >>> sh;
				q.q_j = q.q_j >>> sh;
				q.q_k = q.q_k >>> sh;
			end
			2: begin
				sh = $urandom_range(3);
				if (sh != 0) q.q_real = $signed(qtr_pkg::IN_W'($urandom_range(3))) - 1;
				if (sh != 1) q.q_i = $signed(qtr_pkg::IN_W'($urandom_range(3))) - 1;
				if (sh != 2) q.q_j = $signed(qtr_pkg::IN_W'($urandom_range(3))) - 1;
			end
			default: begin
				q.q_k = q.q_k >>> 12;
				q.q_j = q.q_j >>> $urandom_range(15);
			end
		endcase
		return q;
	endfunction

	// Check each accepted matrix against the oldest expectation.
	always @(posedge clk) begin
		qtr_pkg::mat_t want;
		if (mat.valid && mat.ready) begin
			matrices_seen++;
			if (expected_mats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected matrix %h", mat.data);
			end else begin
				want = expected_mats.pop_front();
				if (mat.data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("matrix mismatch: expected %h actual %h", want, mat.data);
				end
			end
		end
	end

	// Receiver stalls at the current rate.
	always @(posedge clk)
		mat.ready <= ($urandom_range(99) >= stall_pct);

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((quat.valid && quat.ready) || (mat.valid && mat.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("tb failed");
			$finish;
		end
	end

	task automatic test_directed();
		int ext[5] = '{-32768, -1, 0, 1, 32767};
		send_quat(make_quat(0, 0, 0, 0));
		send_quat(make_quat(1, 0, 0, 0));
		send_quat(make_quat(0, 1, 0, 0));
		send_quat(make_quat(0, 0, 1, 0));
		send_quat(make_quat(0, 0, 0, -1));
		send_quat(make_quat(-32768, -32768, -32768, -32768));
		send_quat(make_quat(32767, 32767, 32767, 32767));
		send_quat(make_quat(-32768, 32767, -32768, 32767));
		send_quat(make_quat(1, 1, 1, 1));
		send_quat(make_quat(3, 1, 1, 1));
		send_quat(make_quat(-32768, 0, 0, 1));
		for (int i = 0; i < 10; i++)
			send_quat(make_quat(ext[$urandom_range(4)], ext[$urandom_range(4)],
				ext[$urandom_range(4)], ext[$urandom_range(4)]));
	endtask

	task automatic test_random(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			send_quat(random_quat());
	endtask

	initial begin
		arst_n = 1'b0;
		quat.valid = 1'b0;
		quat.data = '0;
		mat.ready = 1'b0;
		mismatches = 0;
		matrices_seen = 0;
		requests_sent = 0;
		zero_requests = 0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200, 0, 0);
		test_random(120, 83, 0);
		test_random(120, 0, 83);
		test_random(100, 7, 7);
		test_random(60, 0, 0);
		quat.valid <= 1'b0;
		stall_pct = 0;
		while (expected_mats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d quaternion requests (%0d all-zero), %0d matrices checked",
			requests_sent, zero_requests, matrices_seen);
		$display("sender and receiver idled at 0, 7 and 83 percent; %0d mismatches", mismatches);
		if (mismatches == 0 && expected_mats.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

/* files.f */
sv/qtr_pkg.sv
sv/qtr_if.sv
sv/quaternion_to_rotation_matrix.sv
test/tb.sv
